FILE: src/stereo_freeze_looper_defines.svh
// Assertion macros shared by the checker of the stereo freeze looper.
`ifndef STEREO_FREEZE_LOOPER_DEFINES_SVH
`define STEREO_FREEZE_LOOPER_DEFINES_SVH

// Same-cycle implication, sampled on aclk and switched off during reset.
`define SFL_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("stereo_freeze_looper check failed");

// Next-cycle implication, sampled on aclk and switched off during reset.
`define SFL_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("stereo_freeze_looper check failed");

`endif

FILE: src/sfl_pkg.sv
// Shared constants, codes and controller/datapath types of the stereo freeze looper.
package sfl_pkg;

    localparam int MAX_WINDOW  = 262144;
    localparam int ADDR_W      = $clog2(MAX_WINDOW);
    localparam int SAMPLE_BITS = 16;
    localparam int FRAC_BITS   = 8;
    localparam int POS_W       = ADDR_W + FRAC_BITS;
    localparam int MIX_FRAC    = 15;
    localparam int MIX_W       = 16;
    localparam int RATE_W      = 10;
    localparam int CFG_W       = 18;
    localparam int CFG_IDX_W   = 2;

    localparam logic [MIX_W-1:0]  MIX_ONE    = MIX_W'(1 << MIX_FRAC);
    localparam logic [MIX_W-1:0]  MIX_RESET  = MIX_W'(16384);
    localparam logic [RATE_W-1:0] RATE_MIN   = RATE_W'(64);
    localparam logic [RATE_W-1:0] RATE_MAX   = RATE_W'(512);
    localparam logic [RATE_W-1:0] RATE_RESET = RATE_W'(256);
    localparam logic [ADDR_W-1:0] WIN_RESET  = ADDR_W'(24000);

    // Arithmetic widths of the interpolate and mix lanes.
    localparam int DIFF_W   = SAMPLE_BITS + 1;
    localparam int PROD_W   = DIFF_W + FRAC_BITS + 1;
    localparam int INTERP_W = PROD_W + 1;
    localparam int MIXC_W   = MIX_W + 1;
    localparam int WET_W    = INTERP_W + MIXC_W;
    localparam int DRY_W    = SAMPLE_BITS + MIXC_W;
    localparam int TOT_W    = WET_W + 1;
    localparam int SHIFT    = MIX_FRAC + FRAC_BITS;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ENABLE = 2'd0,
        CFG_WINDOW = 2'd1,
        CFG_RATE   = 2'd2,
        CFG_MIX    = 2'd3
    } cfg_reg_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_MUL1,
        ST_MUL2,
        ST_DONE
    } sfl_state_t;

    typedef struct packed {
        logic take;
        logic rd_next;
        logic mul1;
        logic mul2;
        logic finish;
    } sfl_cmd_t;

    typedef struct packed {
        logic play;
        logic out_free;
    } sfl_stat_t;

endpackage

FILE: src/stereo_freeze_looper.sv
// Top level of the stereo freeze looper: controller plus datapath.
//
// Usage: one stereo request (s_left_in, s_right_in) enters on s_valid/s_ready and
// one result request (m_left_out, m_right_out, m_frozen_flag) leaves on
// m_valid/m_ready for every input. Registers are written on cfg_we with
// cfg_index 0 enable, 1 window_length, 2 rate_step, 3 mix_level; the user must
// write them only while idle, as the block itself does not enforce this.
// A write to enable or window_length starts a fresh capture of the window. Bypass
// and capture requests pass from ST_IDLE through ST_DONE to the output register;
// frozen playback requests also pass through ST_READ, ST_MUL1 and ST_MUL2 for the
// two reads of the single-port capture store (base then next entry) and the two
// multiply steps. One request is in flight at a time.
// Reset clears the registers to their defaults and the loop state to zero;
// the capture store is not cleared and holds nothing until captured.
// When the receiver stalls, the finished result waits in the output register
// and the next request is still accepted; its result waits until space frees.
module stereo_freeze_looper
    import sfl_pkg::*;
(
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_we,
    input  logic [CFG_IDX_W-1:0]          cfg_index,
    input  logic [CFG_W-1:0]              cfg_data,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic signed [SAMPLE_BITS-1:0] s_left_in,
    input  logic signed [SAMPLE_BITS-1:0] s_right_in,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic signed [SAMPLE_BITS-1:0] m_left_out,
    output logic signed [SAMPLE_BITS-1:0] m_right_out,
    output logic                          m_frozen_flag
);

    sfl_cmd_t  cmd;
    sfl_stat_t stat;

    sfl_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    sfl_datapath u_datapath (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .left_in       (s_left_in),
        .right_in      (s_right_in),
        .cmd           (cmd),
        .stat          (stat),
        .m_ready       (m_ready),
        .m_valid       (m_valid),
        .m_left_out    (m_left_out),
        .m_right_out   (m_right_out),
        .m_frozen_flag (m_frozen_flag)
    );

endmodule

FILE: src/sfl_ctrl.sv
// Sequencing state machine of the stereo freeze looper.
module sfl_ctrl
    import sfl_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  sfl_stat_t stat,
    output sfl_cmd_t  cmd
);

    sfl_state_t state_reg;
    sfl_state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.take   = 1'b1;
                    state_next = stat.play ? ST_READ : ST_DONE;
                end
            end
            ST_READ: begin
                cmd.rd_next = 1'b1;
                state_next  = ST_MUL1;
            end
            ST_MUL1: begin
                cmd.mul1   = 1'b1;
                state_next = ST_MUL2;
            end
            ST_MUL2: begin
                cmd.mul2   = 1'b1;
                state_next = ST_DONE;
            end
            ST_DONE: begin
                // Hold the result back until the output register can take it.
                if (stat.out_free) begin
                    cmd.finish = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

FILE: src/sfl_datapath.sv
// Capture store, play position, interpolate-and-mix lanes and output register.
module sfl_datapath
    import sfl_pkg::*;
(
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_we,
    input  logic [CFG_IDX_W-1:0]          cfg_index,
    input  logic [CFG_W-1:0]              cfg_data,
    input  logic signed [SAMPLE_BITS-1:0] left_in,
    input  logic signed [SAMPLE_BITS-1:0] right_in,
    input  sfl_cmd_t                      cmd,
    output sfl_stat_t                     stat,
    input  logic                          m_ready,
    output logic                          m_valid,
    output logic signed [SAMPLE_BITS-1:0] m_left_out,
    output logic signed [SAMPLE_BITS-1:0] m_right_out,
    output logic                          m_frozen_flag
);

    localparam int PAIR_W = 2 * SAMPLE_BITS;
    localparam logic signed [TOT_W-1:0] SAT_HI = TOT_W'((1 << (SAMPLE_BITS - 1)) - 1);
    localparam logic signed [TOT_W-1:0] SAT_LO = -SAT_HI - TOT_W'(1);
    localparam logic signed [TOT_W-1:0] ROUND  = TOT_W'(1) <<< (SHIFT - 1);

    // Configuration registers.
    logic              enable_reg;
    logic [ADDR_W-1:0] window_reg;
    logic [RATE_W-1:0] rate_reg;
    logic [MIX_W-1:0]  mix_reg;

    // Loop state.
    logic              snapshot_reg;
    logic [ADDR_W-1:0] cap_idx_reg;
    logic [POS_W-1:0]  pos_reg;
    logic [POS_W:0]    pos_sum_reg;
    logic              flag_reg;

    // Capture store: one port, left sample in the low half of each entry.
    logic [PAIR_W-1:0] store_mem [MAX_WINDOW];
    logic [PAIR_W-1:0] rd_data_reg;
    logic [PAIR_W-1:0] base_reg;
    logic [ADDR_W-1:0] mem_addr;
    logic              mem_we;

    logic signed [SAMPLE_BITS-1:0] dry_in  [2];
    logic signed [SAMPLE_BITS-1:0] dry_reg [2];
    logic signed [PROD_W-1:0]      prod_reg [2];
    logic signed [DRY_W-1:0]       dprod_reg [2];
    logic signed [WET_W-1:0]       wet_reg [2];
    logic signed [SAMPLE_BITS-1:0] mixed [2];
    logic signed [SAMPLE_BITS-1:0] out_reg [2];
    logic                          m_valid_reg;
    logic                          frozen_out_reg;

    logic              bypass;
    logic              restart;
    logic [POS_W-1:0]  span;
    logic [POS_W-1:0]  pos_eff;
    logic [ADDR_W-1:0] cap_eff;
    logic [ADDR_W:0]   cap_inc;
    logic [ADDR_W:0]   next_sum;
    logic [ADDR_W-1:0] next_addr;
    logic [POS_W:0]    pos_wrap1;
    logic [POS_W-1:0]  pos_new;
    logic [RATE_W-1:0] rate_eff;
    logic [MIX_W-1:0]  mix_eff;
    logic [MIX_W-1:0]  mix_inv;
    logic signed [FRAC_BITS:0] frac_s;

    assign dry_in[0] = left_in;
    assign dry_in[1] = right_in;

    assign bypass  = !enable_reg || (window_reg < ADDR_W'(2));
    assign restart = cfg_we && ((cfg_reg_t'(cfg_index) == CFG_ENABLE) ||
                                (cfg_reg_t'(cfg_index) == CFG_WINDOW));
    assign span    = {window_reg, FRAC_BITS'(0)};
    assign pos_eff = (pos_reg >= span) ? '0 : pos_reg;
    assign cap_eff = (cap_idx_reg >= window_reg) ? '0 : cap_idx_reg;
    assign cap_inc = {1'b0, cap_eff} + (ADDR_W + 1)'(1);

    assign next_sum  = {1'b0, pos_reg[POS_W-1:FRAC_BITS]} + (ADDR_W + 1)'(1);
    assign next_addr = (next_sum >= {1'b0, window_reg}) ? '0 : next_sum[ADDR_W-1:0];

    assign rate_eff = (rate_reg < RATE_MIN) ? RATE_MIN :
                      (rate_reg > RATE_MAX) ? RATE_MAX : rate_reg;
    assign mix_eff  = (mix_reg > MIX_ONE) ? MIX_ONE : mix_reg;
    assign mix_inv  = MIX_ONE - mix_eff;
    assign frac_s   = $signed({1'b0, pos_reg[FRAC_BITS-1:0]});

    // Position wrap: subtract the span once, restart at zero if still past it.
    assign pos_wrap1 = (pos_sum_reg >= {1'b0, span}) ? pos_sum_reg - {1'b0, span}
                                                      : pos_sum_reg;
    assign pos_new   = (pos_wrap1 >= {1'b0, span}) ? '0 : pos_wrap1[POS_W-1:0];

    assign stat.play     = !bypass && snapshot_reg;
    assign stat.out_free = !m_valid_reg || m_ready;

    assign mem_we   = cmd.take && !bypass && !snapshot_reg;
    assign mem_addr = cmd.rd_next ? next_addr :
                      (snapshot_reg ? pos_eff[POS_W-1:FRAC_BITS] : cap_eff);

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            store_mem[mem_addr] <= {right_in, left_in};
        end
        rd_data_reg <= store_mem[mem_addr];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            enable_reg <= 1'b0;
            window_reg <= WIN_RESET;
            rate_reg   <= RATE_RESET;
            mix_reg    <= MIX_RESET;
        end else if (cfg_we) begin
            unique case (cfg_reg_t'(cfg_index))
                CFG_ENABLE: enable_reg <= cfg_data[0];
                CFG_WINDOW: window_reg <= cfg_data[ADDR_W-1:0];
                CFG_RATE:   rate_reg   <= cfg_data[RATE_W-1:0];
                CFG_MIX:    mix_reg    <= cfg_data[MIX_W-1:0];
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            snapshot_reg <= 1'b0;
            cap_idx_reg  <= '0;
            pos_reg      <= '0;
            flag_reg     <= 1'b0;
        end else begin
            if (cmd.take) begin
                flag_reg <= stat.play;
                if (mem_we) begin
                    if (cap_inc >= {1'b0, window_reg}) begin
                        snapshot_reg <= 1'b1;
                        cap_idx_reg  <= '0;
                        pos_reg      <= '0;
                    end else begin
                        cap_idx_reg <= cap_inc[ADDR_W-1:0];
                    end
                end else if (stat.play) begin
                    pos_reg <= pos_eff;
                end
            end
            if (cmd.finish && flag_reg) begin
                pos_reg <= pos_new;
            end
            // A write to enable or window_length starts a fresh capture.
            if (restart) begin
                snapshot_reg <= 1'b0;
                cap_idx_reg  <= '0;
                pos_reg      <= '0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.rd_next) begin
            base_reg <= rd_data_reg;
        end
        if (cmd.mul1) begin
            pos_sum_reg <= {1'b0, pos_reg} + (POS_W + 1)'(rate_eff);
        end
    end

    for (genvar ch = 0; ch < 2; ch++) begin : g_lane
        logic signed [SAMPLE_BITS-1:0] a_s;
        logic signed [SAMPLE_BITS-1:0] b_s;
        logic signed [DIFF_W-1:0]      diff;
        logic signed [INTERP_W-1:0]    interp;
        logic signed [TOT_W-1:0]       total;
        logic signed [TOT_W-1:0]       scaled;

        assign a_s    = $signed(base_reg[ch*SAMPLE_BITS +: SAMPLE_BITS]);
        assign b_s    = $signed(rd_data_reg[ch*SAMPLE_BITS +: SAMPLE_BITS]);
        assign diff   = DIFF_W'(b_s) - DIFF_W'(a_s);
        assign interp = (INTERP_W'(a_s) <<< FRAC_BITS) + INTERP_W'(prod_reg[ch]);
        assign total  = (TOT_W'(dprod_reg[ch]) <<< FRAC_BITS) + TOT_W'(wet_reg[ch]) + ROUND;
        assign scaled = total >>> SHIFT;
        assign mixed[ch] = (scaled > SAT_HI) ? SAT_HI[SAMPLE_BITS-1:0] :
                           (scaled < SAT_LO) ? SAT_LO[SAMPLE_BITS-1:0] :
                           scaled[SAMPLE_BITS-1:0];

        always_ff @(posedge aclk) begin
            if (cmd.take) begin
                dry_reg[ch] <= dry_in[ch];
            end
            if (cmd.mul1) begin
                prod_reg[ch]  <= diff * frac_s;
                dprod_reg[ch] <= DRY_W'(dry_reg[ch]) * $signed({1'b0, mix_inv});
            end
            if (cmd.mul2) begin
                wet_reg[ch] <= interp * $signed({1'b0, mix_eff});
            end
            if (cmd.finish) begin
                out_reg[ch] <= flag_reg ? mixed[ch] : dry_reg[ch];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.finish) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.finish) begin
            frozen_out_reg <= flag_reg;
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_left_out    = out_reg[0];
    assign m_right_out   = out_reg[1];
    assign m_frozen_flag = frozen_out_reg;

endmodule

FILE: src/sfl_checker.sv
// Port-level checker of the stereo freeze looper and its bind.
`include "stereo_freeze_looper_defines.svh"

module sfl_checker
    import sfl_pkg::*;
(
    input logic                          aclk,
    input logic                          aresetn,
    input logic                          s_valid,
    input logic                          s_ready,
    input logic                          m_valid,
    input logic                          m_ready,
    input logic signed [SAMPLE_BITS-1:0] m_left_out,
    input logic signed [SAMPLE_BITS-1:0] m_right_out,
    input logic                          m_frozen_flag
);

    // A stalled result keeps its request and payload.
    `SFL_ASSERT_NXT(a_out_hold, m_valid && !m_ready, m_valid && $stable(m_frozen_flag))
    `SFL_ASSERT_NXT(a_data_hold, m_valid && !m_ready, $stable({m_left_out, m_right_out}))

    // One request in flight: the input closes right after an acceptance.
    `SFL_ASSERT_NXT(a_one_in_flight, s_valid && s_ready, !s_ready)

    // No result can appear in the cycle straight after an acceptance.
    `SFL_ASSERT_NXT(a_min_latency, s_valid && s_ready, !$rose(m_valid))

    // The input stays closed while a result is produced.
    `SFL_ASSERT_IMP(a_rise_after_work, $rose(m_valid), !$past(s_ready))

endmodule

bind stereo_freeze_looper sfl_checker u_sfl_checker (.*);
